// ===== design/sct_pkg.sv =====
// Shared types and codes for the sorted coordinate table.
package sct_pkg;

  localparam int POS_W = 11;
  localparam int KEY_W = 40;

  // Request kinds
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic             req_type;
    logic [15:0]      key_x;
    logic [15:0]      key_y;
    logic [7:0]       key_z;
    logic [POS_W-1:0] insert_position;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_count;
    logic [1:0]       status;
  } out_item_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic             ins_en;
    logic             cmp_en;
    logic [POS_W-1:0] pos;
    key_t             key;
  } cell_cmd_t;

  // Search unit status toward the controller
  typedef struct packed {
    logic done;
    logic found;
  } srch_stat_t;

endpackage

// ===== design/sct_if.sv =====
// Valid/ready channel interfaces for request and result items.
interface sct_in_if;
  logic               valid;
  logic               ready;
  sct_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface sct_out_if;
  logic               valid;
  logic               ready;
  sct_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== design/sct_cell.sv =====
// One table slot: holds an entry, shifts up on insert, compares against the key.
module sct_cell #(
  parameter int IDX = 0,
  parameter int CW  = 11
) (
  input  logic                clk,
  input  sct_pkg::cell_cmd_t  cmd,
  input  logic [CW-1:0]       count,
  input  sct_pkg::key_t       prev_entry,
  output sct_pkg::key_t       entry,
  output logic                lt,
  output logic                eq
);

  localparam int CMPW = (CW > sct_pkg::POS_W) ? CW : sct_pkg::POS_W;
  localparam logic [CMPW-1:0] IDX_C = CMPW'(IDX);

  sct_pkg::key_t   entry_r;
  logic            lt_r;
  logic            eq_r;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] count_ext;
  logic            load;
  logic            shift;

  assign pos_ext   = CMPW'(cmd.pos);
  assign count_ext = CMPW'(count);

  // slot at the insert index takes the key, slots above it up to count take the neighbor
  assign load  = cmd.ins_en && (pos_ext == IDX_C);
  assign shift = cmd.ins_en && (pos_ext < IDX_C) && (IDX_C <= count_ext);

  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= cmd.key;
    end else if (shift) begin
      entry_r <= prev_entry;
    end
  end

  // compare flags captured once per lookup
  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      lt_r <= (entry_r < cmd.key);
      eq_r <= (entry_r == cmd.key);
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

// ===== design/sct_search.sv =====
// Lower-bound binary search over the per-cell compare flags, one probe per cycle.
module sct_search #(
  parameter int CAPACITY = 1024,
  parameter int IW       = 10,
  parameter int CW       = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CW-1:0]        count,
  input  logic [CAPACITY-1:0]  lt_vec,
  input  logic [CAPACITY-1:0]  eq_vec,
  output sct_pkg::srch_stat_t  stat,
  output logic [CW-1:0]        pos
);

  logic          busy_r;
  logic [CW-1:0] lo_r;
  logic [CW-1:0] hi_r;
  logic [CW-1:0] mid;
  logic          open;

  assign open = (lo_r < hi_r);
  assign mid  = lo_r + ((hi_r - lo_r) >> 1);

  // window update
  always_ff @(posedge clk) begin
    if (start) begin
      lo_r <= '0;
      hi_r <= count;
    end else if (busy_r && open) begin
      if (lt_vec[mid[IW-1:0]]) begin
        lo_r <= CW'(mid + 1'b1);
      end else begin
        hi_r <= mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (stat.done) begin
      busy_r <= 1'b0;
    end
  end

  // lo reaches the capacity only when the count does, so the wrapped index is never used then
  assign stat.done  = busy_r && !open;
  assign stat.found = (lo_r < count) && eq_vec[lo_r[IW-1:0]];
  assign pos        = lo_r;

endmodule

// ===== design/sorted_coordinate_table.sv =====
// Lookup: the cells capture their compare flags, then the search unit probes one compare flag
//   per cycle until its window closes, and the result goes to the output register.
// Insert: the whole cell row shifts together in the insert state; a rejected insert skips that state.
// One item in flight; a new item is taken while the previous result waits in the output register.
// Reset (synchronous, active low) clears the entry count and the control; entries keep
//   their contents and are only read below the count.
module sorted_coordinate_table #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  sct_in_if.sink            in_ch,
  sct_out_if.source         out_ch
);

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > sct_pkg::POS_W) ? CW : sct_pkg::POS_W;
  localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  sct_pkg::in_item_t          req_r, req_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic                       found_r, found_nxt;
  logic [sct_pkg::POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic                       out_valid_r, out_valid_nxt;
  sct_pkg::out_item_t         out_item_r, out_item_nxt;

  sct_pkg::cell_cmd_t         cmd;
  sct_pkg::key_t              entry [CAPACITY];
  logic [CAPACITY-1:0]        lt_vec;
  logic [CAPACITY-1:0]        eq_vec;
  sct_pkg::srch_stat_t        srch_stat;
  logic [CW-1:0]              srch_pos;
  logic [CMPW-1:0]            srch_pos_ext;
  logic [CMPW-1:0]            count_ext;
  logic [CMPW-1:0]            in_pos_ext;
  logic                       in_acc;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  assign count_ext    = CMPW'(count_r);
  assign in_pos_ext   = CMPW'(in_ch.item.insert_position);
  assign srch_pos_ext = CMPW'(srch_pos);

  // broadcast command to the cell row
  assign cmd.ins_en = (state_r == S_INS);
  assign cmd.cmp_en = (state_r == S_CMP);
  assign cmd.pos    = req_r.insert_position;
  assign cmd.key    = {req_r.key_x, req_r.key_y, req_r.key_z};

  // row of cells, each fed by its lower neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sct_pkg::key_t prev;
    if (i == 0) begin : g_first
      assign prev = cmd.key;
    end else begin : g_rest
      assign prev = entry[i-1];
    end
    sct_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .prev_entry (prev),
      .entry      (entry[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  sct_search #(.CAPACITY(CAPACITY), .IW(IW), .CW(CW)) u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_CMP),
    .count  (count_r),
    .lt_vec (lt_vec),
    .eq_vec (eq_vec),
    .stat   (srch_stat),
    .pos    (srch_pos)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt     = in_ch.item;
          found_nxt   = 1'b0;
          status_nxt  = sct_pkg::ST_OK;
          res_pos_nxt = in_ch.item.insert_position;
          if (in_ch.item.req_type == sct_pkg::REQ_INSERT) begin
            if (count_ext >= CAP_C) begin
              status_nxt = sct_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else if (in_pos_ext > count_ext) begin
              status_nxt = sct_pkg::ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt  = S_INS;
            end
          end else begin
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (srch_stat.done) begin
          found_nxt   = srch_stat.found;
          res_pos_nxt = srch_pos_ext[sct_pkg::POS_W-1:0];
          state_nxt   = S_DONE;
        end
      end
      S_INS: begin
        count_nxt = CW'(count_r + 1'b1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.found       = found_r;
          out_item_nxt.position    = res_pos_r;
          out_item_nxt.entry_count = count_ext[sct_pkg::POS_W-1:0];
          out_item_nxt.status      = status_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    res_pos_r  <= res_pos_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// ===== design/sct_checker.sv =====
// Port-level checks on the result stream of the sorted coordinate table.
module sct_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       found,
  input logic [sct_pkg::POS_W-1:0]  position,
  input logic [sct_pkg::POS_W-1:0]  entry_count,
  input logic [1:0]                 status
);

  logic [sct_pkg::POS_W-1:0] last_count_r;
  logic                      out_acc;

  assign out_acc = out_valid && out_ready;

  // count seen on the previous delivered item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
    end else if (out_acc) begin
      last_count_r <= entry_count;
    end
  end

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a hit is a clean lookup inside the used range
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> (status == sct_pkg::ST_OK) && (position < entry_count))
    else $error("hit with bad status or position");

  // the count grows by at most one per item
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (entry_count == last_count_r) ||
                (entry_count == sct_pkg::POS_W'(last_count_r + 1'b1)))
    else $error("entry count jumped");

  // a rejected insert leaves the count alone
  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (status != sct_pkg::ST_OK) |-> (entry_count == last_count_r))
    else $error("rejected insert changed the count");

endmodule

bind sorted_coordinate_table sct_checker u_sct_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .found       (out_ch.item.found),
  .position    (out_ch.item.position),
  .entry_count (out_ch.item.entry_count),
  .status      (out_ch.item.status)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the sorted coordinate table: directed and random lookups and inserts.
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_CAP = 1024;
  localparam int RANDOM_ITEMS = 1500;
  localparam int FULL_ITEMS_MIN = 40;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Driven copies of the handshake signals, known from time zero
  logic               req_valid = 1'b0;
  sct_pkg::in_item_t  req_item = '0;
  logic               res_ready = 1'b0;

  sct_in_if  in_ch();
  sct_out_if out_ch();

  assign in_ch.valid  = req_valid;
  assign in_ch.item   = req_item;
  assign out_ch.ready = res_ready;

  sorted_coordinate_table #(.CAPACITY(TABLE_CAP)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Table copies: index 0 tracks accepted items, index 1 tracks generated ones
  sct_pkg::key_t tbl_keys [2][TABLE_CAP];
  int            tbl_count [2];

  sct_pkg::in_item_t  request_queue[$];
  sct_pkg::out_item_t predicted_results[$];

  int fails = 0;
  int req_sent = 0;
  int results_seen = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int cycle_count = 0;

  // Lower bound over the entries in use of one table copy
  function automatic int key_lower_bound(int s, sct_pkg::key_t k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = tbl_count[s];
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (tbl_keys[s][mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Applies one request to a table copy and returns the result it gives
  function automatic sct_pkg::out_item_t table_apply(int s, sct_pkg::in_item_t r);
    sct_pkg::out_item_t res;
    sct_pkg::key_t      k;
    int                 idx;
    k = {r.key_x, r.key_y, r.key_z};
    res = '0;
    res.status = sct_pkg::ST_OK;
    if (r.req_type == sct_pkg::REQ_LOOKUP) begin
      idx = key_lower_bound(s, k);
      res.found = (idx < tbl_count[s]) && (tbl_keys[s][idx] == k);
      res.position = sct_pkg::POS_W'(idx);
    end else begin
      idx = int'(r.insert_position);
      res.position = r.insert_position;
      if (tbl_count[s] >= TABLE_CAP) begin
        res.status = sct_pkg::ST_FULL;
      end else if (idx > tbl_count[s]) begin
        res.status = sct_pkg::ST_RANGE;
      end else begin
        for (int i = tbl_count[s]; i > idx; i--) tbl_keys[s][i] = tbl_keys[s][i - 1];
        tbl_keys[s][idx] = k;
        tbl_count[s]++;
      end
    end
    res.entry_count = sct_pkg::POS_W'(tbl_count[s]);
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and whole stretches without any
  function automatic int pick_gap(int n);
    int r;
    if ((n / 100) % 5 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random key; small coordinates make ties on x and y common
  function automatic sct_pkg::key_t rand_key();
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  z;
    x = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    y = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    z = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    return {x, y, z};
  endfunction

  // Key already in the generated table copy, or a random one if it is empty
  function automatic sct_pkg::key_t stored_key();
    if (tbl_count[1] == 0) return rand_key();
    return tbl_keys[1][$urandom_range(0, tbl_count[1] - 1)];
  endfunction

  task automatic push_req(input logic t, input sct_pkg::key_t k,
                          input logic [sct_pkg::POS_W-1:0] p);
    sct_pkg::in_item_t it;
    it.req_type = t;
    it.key_x = k[39:24];
    it.key_y = k[23:8];
    it.key_z = k[7:0];
    it.insert_position = p;
    request_queue.push_back(it);
    void'(table_apply(1, it));
  endtask

  // Stimulus, reset and end of run
  initial begin
    sct_pkg::key_t k;
    int            r;
    int            n_rand;
    int            full_seen;
    n_rand = 0;
    full_seen = 0;
    for (int s = 0; s < 2; s++) begin
      tbl_count[s] = 0;
      for (int i = 0; i < TABLE_CAP; i++) tbl_keys[s][i] = '0;
    end

    // Directed: empty table, range errors, tie-breaks, duplicates, lookups
    push_req(sct_pkg::REQ_LOOKUP, {16'h0000, 16'h0000, 8'h00}, 11'd0);
    push_req(sct_pkg::REQ_LOOKUP, {16'hffff, 16'hffff, 8'hff}, 11'h7ff);
    push_req(sct_pkg::REQ_INSERT, {16'h1000, 16'h2000, 8'h30}, 11'd1);
    push_req(sct_pkg::REQ_INSERT, {16'h1000, 16'h2000, 8'h30}, 11'h7ff);
    push_req(sct_pkg::REQ_INSERT, {16'h1000, 16'h2000, 8'h30}, 11'd0);
    push_req(sct_pkg::REQ_INSERT, {16'h0000, 16'h0000, 8'h00}, 11'd0);
    push_req(sct_pkg::REQ_INSERT, {16'hffff, 16'hffff, 8'hff}, 11'd2);
    push_req(sct_pkg::REQ_INSERT, {16'h1000, 16'h2000, 8'h31}, 11'd2);
    push_req(sct_pkg::REQ_INSERT, {16'h1000, 16'h2001, 8'h00}, 11'd3);
    push_req(sct_pkg::REQ_INSERT, {16'h1000, 16'h2000, 8'h30}, 11'd1);
    push_req(sct_pkg::REQ_LOOKUP, {16'h0000, 16'h0000, 8'h00}, 11'd0);
    push_req(sct_pkg::REQ_LOOKUP, {16'hffff, 16'hffff, 8'hff}, 11'd0);
    push_req(sct_pkg::REQ_LOOKUP, {16'h1000, 16'h2000, 8'h30}, 11'd0);
    push_req(sct_pkg::REQ_LOOKUP, {16'h1000, 16'h2000, 8'h2f}, 11'd0);
    push_req(sct_pkg::REQ_LOOKUP, {16'h1000, 16'h2000, 8'h32}, 11'd0);
    push_req(sct_pkg::REQ_LOOKUP, {16'h0fff, 16'hffff, 8'hff}, 11'h7ff);
    push_req(sct_pkg::REQ_LOOKUP, {16'hffff, 16'hffff, 8'hfe}, 11'd0);
    push_req(sct_pkg::REQ_INSERT, {16'h8000, 16'h0000, 8'h80}, 11'd5);
    push_req(sct_pkg::REQ_INSERT, {16'h8000, 16'h0000, 8'h80}, 11'd8);
    push_req(sct_pkg::REQ_LOOKUP, {16'h8000, 16'h0000, 8'h80}, 11'd0);
    // out-of-order append leaves the table unsorted from here on
    push_req(sct_pkg::REQ_INSERT, {16'h0000, 16'h0000, 8'h01}, 11'd7);
    push_req(sct_pkg::REQ_LOOKUP, {16'h0000, 16'h0000, 8'h01}, 11'd0);

    // Random: mostly sorted inserts so the table fills, then keep going while full
    while (n_rand < RANDOM_ITEMS || full_seen < FULL_ITEMS_MIN) begin
      r = $urandom_range(0, 99);
      k = ($urandom_range(0, 3) == 0) ? stored_key() : rand_key();
      if (r < 76) begin
        if (tbl_count[1] >= TABLE_CAP) begin
          full_seen++;
          if ($urandom_range(0, 1) == 0)
            push_req(sct_pkg::REQ_INSERT, k, 11'($urandom));
          else
            push_req(sct_pkg::REQ_INSERT, k, sct_pkg::POS_W'(key_lower_bound(1, k)));
        end else if (r < 72) begin
          push_req(sct_pkg::REQ_INSERT, k, sct_pkg::POS_W'(key_lower_bound(1, k)));
        end else if (r < 74) begin
          push_req(sct_pkg::REQ_INSERT, k, 11'($urandom));
        end else begin
          push_req(sct_pkg::REQ_INSERT, k,
                   sct_pkg::POS_W'($urandom_range(0, tbl_count[1])));
        end
      end else begin
        if ($urandom_range(0, 4) < 3) k = stored_key();
        push_req(sct_pkg::REQ_LOOKUP, k, 11'($urandom));
      end
      n_rand++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() != 0 || predicted_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0) begin
      $error("%0d expected results never arrived", predicted_results.size());
      fails++;
    end
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Request driver: predicts each item as it is accepted
  always @(posedge clk) begin
    logic              nxt_valid;
    sct_pkg::in_item_t nxt_item;
    nxt_valid = req_valid;
    nxt_item = req_item;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (req_valid && in_ch.ready) begin
        predicted_results.push_back(table_apply(0, req_item));
        void'(request_queue.pop_front());
        req_sent++;
        nxt_valid = 1'b0;
        send_gap = pick_gap(req_sent);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_queue.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_item = request_queue[0];
        end
      end
    end
    req_valid <= nxt_valid;
    req_item <= nxt_item;
  end

  // Result monitor: compares against the oldest prediction, stalls at random
  always @(posedge clk) begin
    sct_pkg::out_item_t want;
    logic               nxt_ready;
    nxt_ready = res_ready;
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else begin
      if (out_ch.valid && res_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result with no item outstanding");
          fails++;
        end else begin
          want = predicted_results.pop_front();
          if (out_ch.item.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_ch.item.found);
            fails++;
          end
          if (out_ch.item.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, out_ch.item.position);
            fails++;
          end
          if (out_ch.item.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, out_ch.item.entry_count);
            fails++;
          end
          if (out_ch.item.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.item.status);
            fails++;
          end
        end
        results_seen++;
        recv_gap = pick_gap(results_seen);
        // one long hold-off so the block backs up and stalls its input
        if (results_seen == 150) recv_gap = 400;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    res_ready <= nxt_ready;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
design/sct_pkg.sv
design/sct_if.sv
design/sct_cell.sv
design/sct_search.sv
design/sorted_coordinate_table.sv
design/sct_checker.sv
bench/testbench.sv
